>>> hw/rtl/rdbs_pkg.sv
package rdbs_pkg;

  localparam int REGION_COUNT = 16;
  localparam int REGION_W     = 4;
  localparam int ALU_W        = 33;
  localparam int CFG_IDX_W    = 2;

  localparam logic [14:0] IP_START = 15'd14;
  localparam logic [14:0] BUF_MIN  = 15'd2048;
  localparam logic [14:0] BUF_MAX  = 15'd16384;
  localparam logic [19:0] LEN_MAX  = 20'hFFFFF;
  localparam logic [7:0]  SEG_MAX  = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IP_MODE      = 2'd1;

  localparam logic CMD_DESC  = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  typedef struct packed {
    logic [14:0] buffer_bytes;
    logic        ip_mode;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [REGION_W-1:0] idx;
    logic [31:0]         data;
  } tbl_wr_t;

  typedef struct packed {
    logic [REGION_W-1:0] src_region;
    logic [32:0]         src_offset;
    logic [14:0]         copy_bytes;
    logic [13:0]         dst_offset;
    logic [7:0]          segment_index;
    logic                overrun;
    logic                packet_done;
    logic [19:0]         packet_bytes;
    logic                last;
  } res_t;

endpackage

>>> hw/rtl/rdbs_cfg.sv
module rdbs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [rdbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [14:0]                       cfg_data,
  input  rdbs_pkg::tbl_wr_t                 tbl_wr,
  input  logic [rdbs_pkg::REGION_W-1:0]     rd_idx,
  output logic [31:0]                       rd_size,
  output rdbs_pkg::cfg_t                    cfg
);

  logic [31:0]    tbl_r [rdbs_pkg::REGION_COUNT];
  rdbs_pkg::cfg_t cfg_r;
  logic [14:0]    buf_sat;

  // buffer size is clamped into its legal range on write
  always_comb begin
    buf_sat = cfg_data;
    if (cfg_data < rdbs_pkg::BUF_MIN) begin
      buf_sat = rdbs_pkg::BUF_MIN;
    end else if (cfg_data > rdbs_pkg::BUF_MAX) begin
      buf_sat = rdbs_pkg::BUF_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_bytes <= rdbs_pkg::BUF_MIN;
      cfg_r.ip_mode      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rdbs_pkg::REG_BUFFER_BYTES: cfg_r.buffer_bytes <= buf_sat;
        rdbs_pkg::REG_IP_MODE:      cfg_r.ip_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rdbs_pkg::REGION_COUNT; i++) begin
        tbl_r[i] <= 32'd0;
      end
    end else if (tbl_wr.en) begin
      tbl_r[tbl_wr.idx] <= tbl_wr.data;
    end
  end

  assign rd_size = tbl_r[rd_idx];
  assign cfg     = cfg_r;

endmodule

>>> hw/rtl/rdbs_alu.sv
module rdbs_alu (
  input  logic [rdbs_pkg::ALU_W-1:0] a,
  input  logic [rdbs_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  output logic [rdbs_pkg::ALU_W-1:0] res,
  output logic                       borrow
);

  logic [rdbs_pkg::ALU_W:0]   full;
  logic [rdbs_pkg::ALU_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign full = {1'b0, a} + {1'b0, b_op} + {{rdbs_pkg::ALU_W{1'b0}}, sub};
  assign res  = full[rdbs_pkg::ALU_W-1:0];
  // carry out on add, borrow (a < b) on subtract
  assign borrow = sub ? ~full[rdbs_pkg::ALU_W] : full[rdbs_pkg::ALU_W];

endmodule

>>> hw/rtl/rdbs_engine.sv
module rdbs_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [rdbs_pkg::REGION_W-1:0] in_region_index,
  input  logic [31:0]                   in_desc_offset,
  input  logic [15:0]                   in_desc_length,
  input  logic                          in_chain_next,
  input  logic                          in_ring_end,
  input  logic [31:0]                   in_region_bytes,
  input  rdbs_pkg::cfg_t                cfg,
  output rdbs_pkg::tbl_wr_t             tbl_wr,
  output logic [rdbs_pkg::REGION_W-1:0] rd_idx,
  input  logic [31:0]                   rd_size,
  output logic                          res_valid,
  input  logic                          res_ready,
  output rdbs_pkg::res_t                res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_BAD  = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_TAKE = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [rdbs_pkg::REGION_W-1:0] region_r, region_nxt;
  logic [15:0]                  len_r, len_nxt;
  logic                         done_r, done_nxt;
  logic [32:0]                  sum_r, sum_nxt;
  logic [32:0]                  src_r, src_nxt;
  logic [15:0]                  left_r, left_nxt;
  logic [14:0]                  free_r, free_nxt;
  logic [14:0]                  fill_r, fill_nxt;
  logic [7:0]                   seg_r, seg_nxt;
  logic [19:0]                  plen_r, plen_nxt;
  logic                         pstart_r, pstart_nxt;

  logic [rdbs_pkg::ALU_W-1:0] alu_a, alu_b, alu_res;
  logic                       alu_sub, alu_borrow;

  logic [20:0] plen_sum;
  logic [14:0] take;
  logic [15:0] left_after;
  logic        accept;

  rdbs_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign rd_idx   = region_r;

  // one adder serves the end sum, the end check, free space and chunk size in turn
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_IDLE: begin
        alu_a = {1'b0, in_desc_offset};
        alu_b = {17'd0, in_desc_length};
      end
      S_CHK: begin
        alu_a   = {1'b0, rd_size};
        alu_b   = sum_r;
        alu_sub = 1'b1;
      end
      S_FREE: begin
        alu_a   = {18'd0, cfg.buffer_bytes};
        alu_b   = {18'd0, fill_r};
        alu_sub = 1'b1;
      end
      S_TAKE: begin
        alu_a   = {17'd0, left_r};
        alu_b   = {18'd0, free_r};
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign plen_sum   = {1'b0, (pstart_r ? 20'd0 : plen_r)} + {5'd0, len_r};
  // left below free means the rest fits in this buffer
  assign take       = alu_borrow ? left_r[14:0] : free_r;
  assign left_after = alu_borrow ? 16'd0 : alu_res[15:0];

  always_comb begin
    state_nxt  = state_r;
    region_nxt = region_r;
    len_nxt    = len_r;
    done_nxt   = done_r;
    sum_nxt    = sum_r;
    src_nxt    = src_r;
    left_nxt   = left_r;
    free_nxt   = free_r;
    fill_nxt   = fill_r;
    seg_nxt    = seg_r;
    plen_nxt   = plen_r;
    pstart_nxt = pstart_r;
    tbl_wr     = '0;
    res_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == rdbs_pkg::CMD_TABLE) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.idx  = in_region_index;
            tbl_wr.data = in_region_bytes;
          end else begin
            region_nxt = in_region_index;
            len_nxt    = in_desc_length;
            done_nxt   = !in_chain_next || in_ring_end;
            sum_nxt    = alu_res;
            src_nxt    = {1'b0, in_desc_offset};
            state_nxt  = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (pstart_r) begin
          fill_nxt = cfg.ip_mode ? rdbs_pkg::IP_START : 15'd0;
          seg_nxt  = 8'd0;
        end
        plen_nxt   = plen_sum[20] ? rdbs_pkg::LEN_MAX : plen_sum[19:0];
        pstart_nxt = done_r;
        left_nxt   = len_r;
        state_nxt  = alu_borrow ? S_BAD : S_FREE;
      end
      S_BAD: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        // full buffer, also when the buffer size shrank below the fill
        if (alu_borrow || (alu_res[14:0] == 15'd0)) begin
          fill_nxt = 15'd0;
          free_nxt = cfg.buffer_bytes;
          if (seg_r != rdbs_pkg::SEG_MAX) begin
            seg_nxt = seg_r + 8'd1;
          end
        end else begin
          free_nxt = alu_res[14:0];
        end
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          left_nxt  = left_after;
          fill_nxt  = fill_r + take;
          src_nxt   = src_r + {18'd0, take};
          state_nxt = (left_after == 16'd0) ? S_IDLE : S_FREE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.src_region    = region_r;
    res.segment_index = seg_r;
    res.packet_bytes  = plen_r;
    if (state_r == S_BAD) begin
      res.src_offset  = 33'd0;
      res.copy_bytes  = 15'd0;
      res.dst_offset  = 14'd0;
      res.overrun     = 1'b1;
      res.last        = 1'b1;
      res.packet_done = done_r;
    end else begin
      res.src_offset  = src_r;
      res.copy_bytes  = take;
      res.dst_offset  = fill_r[13:0];
      res.overrun     = 1'b0;
      res.last        = (left_after == 16'd0);
      res.packet_done = done_r && (left_after == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= 15'd0;
      seg_r    <= 8'd0;
      plen_r   <= 20'd0;
      pstart_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      seg_r    <= seg_nxt;
      plen_r   <= plen_nxt;
      pstart_r <= pstart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    region_r <= region_nxt;
    len_r    <= len_nxt;
    done_r   <= done_nxt;
    sum_r    <= sum_nxt;
    src_r    <= src_nxt;
    left_r   <= left_nxt;
    free_r   <= free_nxt;
  end

endmodule

>>> hw/rtl/rx_descriptor_buffer_segmenter_top.sv
// Receive descriptor segmenter: splits ring descriptors into buffer copy items.
// Input channel (in_valid / in_stall): one item is either a descriptor
// (in_cmd 0) or a region size table write (in_cmd 1). The block stalls the
// input while it works on a descriptor; a table write leaves the input free.
// Output channel (out_valid / out_stall): one item per copy operation, or a
// single item flagged overrun when the descriptor runs past its region.
// Each result sits in an output register, so a stalled receiver only holds
// the sequencer, nothing is lost or repeated.
// Steps: a descriptor goes through a check step, then one free-space and one
// size step through the shared adder for each copy; a bad descriptor goes
// from the check step straight to its overrun result. The input stays
// stalled until the last result of a descriptor is taken.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 buffer size,
// clamped to 2048..16384; index 1 IP mode. Write only while idle.
// Reset (rst_n low, synchronous): buffer size 2048, ethernet mode, region
// size table all zero, next descriptor starts a new packet.
module rx_descriptor_buffer_segmenter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [3:0]                    in_region_index,
  input  logic [31:0]                   in_desc_offset,
  input  logic [15:0]                   in_desc_length,
  input  logic                          in_chain_next,
  input  logic                          in_ring_end,
  input  logic [31:0]                   in_region_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_src_region,
  output logic [32:0]                   out_src_offset,
  output logic [14:0]                   out_copy_bytes,
  output logic [13:0]                   out_dst_offset,
  output logic [7:0]                    out_segment_index,
  output logic                          out_overrun,
  output logic                          out_packet_done,
  output logic [19:0]                   out_packet_bytes,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rdbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [14:0]                   cfg_data
);

  rdbs_pkg::cfg_t    cfg;
  rdbs_pkg::tbl_wr_t tbl_wr;
  rdbs_pkg::res_t    res;
  rdbs_pkg::res_t    out_r;
  logic [rdbs_pkg::REGION_W-1:0] rd_idx;
  logic [31:0]       rd_size;
  logic              res_valid, res_ready;
  logic              out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;

  rdbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tbl_wr    (tbl_wr),
    .rd_idx    (rd_idx),
    .rd_size   (rd_size),
    .cfg       (cfg)
  );

  rdbs_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_region_index (in_region_index),
    .in_desc_offset  (in_desc_offset),
    .in_desc_length  (in_desc_length),
    .in_chain_next   (in_chain_next),
    .in_ring_end     (in_ring_end),
    .in_region_bytes (in_region_bytes),
    .cfg             (cfg),
    .tbl_wr          (tbl_wr),
    .rd_idx          (rd_idx),
    .rd_size         (rd_size),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // output register takes a new item when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_src_region    = out_r.src_region;
  assign out_src_offset    = out_r.src_offset;
  assign out_copy_bytes    = out_r.copy_bytes;
  assign out_dst_offset    = out_r.dst_offset;
  assign out_segment_index = out_r.segment_index;
  assign out_overrun       = out_r.overrun;
  assign out_packet_done   = out_r.packet_done;
  assign out_packet_bytes  = out_r.packet_bytes;
  assign out_last          = out_r.last;

endmodule

>>> dv/tb.sv
module tb;

  localparam logic [rdbs_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [rdbs_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
  localparam int MAX_COPIES  = 33;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct {
    logic        cmd;
    logic [3:0]  region;
    logic [31:0] offset;
    logic [15:0] length;
    logic        chain;
    logic        ring_end;
    logic [31:0] rbytes;
  } ring_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = rdbs_pkg::CMD_DESC;
  logic [3:0]  in_region_index = '0;
  logic [31:0] in_desc_offset = '0;
  logic [15:0] in_desc_length = '0;
  logic        in_chain_next = 1'b0;
  logic        in_ring_end = 1'b0;
  logic [31:0] in_region_bytes = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_src_region;
  logic [32:0] out_src_offset;
  logic [14:0] out_copy_bytes;
  logic [13:0] out_dst_offset;
  logic [7:0]  out_segment_index;
  logic        out_overrun;
  logic        out_packet_done;
  logic [19:0] out_packet_bytes;
  logic        out_last;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rdbs_pkg::CFG_IDX_W-1:0] cfg_index = rdbs_pkg::REG_BUFFER_BYTES;
  logic [14:0]                    cfg_data = '0;

  rx_descriptor_buffer_segmenter_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_region_index   (in_region_index),
    .in_desc_offset    (in_desc_offset),
    .in_desc_length    (in_desc_length),
    .in_chain_next     (in_chain_next),
    .in_ring_end       (in_ring_end),
    .in_region_bytes   (in_region_bytes),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_src_region    (out_src_region),
    .out_src_offset    (out_src_offset),
    .out_copy_bytes    (out_copy_bytes),
    .out_dst_offset    (out_dst_offset),
    .out_segment_index (out_segment_index),
    .out_overrun       (out_overrun),
    .out_packet_done   (out_packet_done),
    .out_packet_bytes  (out_packet_bytes),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic [31:0] rgn_size [rdbs_pkg::REGION_COUNT];
  int unsigned fill_pos;
  int unsigned seg_cnt;
  int unsigned pkt_len;
  bit          new_pkt;
  int unsigned bufsz;
  bit          ip_on;

  rdbs_pkg::res_t pending_copies [$];
  int   mismatches = 0;

  // pacing knobs
  int  gap_max = 0;
  int  burst_left = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;

  function automatic void reset_model();
    foreach (rgn_size[i]) rgn_size[i] = '0;
    fill_pos = 0;
    seg_cnt  = 0;
    pkt_len  = 0;
    new_pkt  = 1'b1;
    bufsz    = 32'(rdbs_pkg::BUF_MIN);
    ip_on    = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [rdbs_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [14:0] val);
    case (idx)
      rdbs_pkg::REG_BUFFER_BYTES: begin
        if (val < rdbs_pkg::BUF_MIN) bufsz = 32'(rdbs_pkg::BUF_MIN);
        else if (val > rdbs_pkg::BUF_MAX) bufsz = 32'(rdbs_pkg::BUF_MAX);
        else bufsz = 32'(val);
      end
      rdbs_pkg::REG_IP_MODE: ip_on = val[0];
      default: ;
    endcase
  endfunction

  // works out the copy items one accepted item causes
  function automatic void split_descriptor(input ring_item_t it);
    longint unsigned ofs, src_pos, left, room, take;
    int   n;
    bit   pkt_end;
    rdbs_pkg::res_t r;
    if (it.cmd == rdbs_pkg::CMD_TABLE) begin
      rgn_size[it.region] = it.rbytes;
      return;
    end
    if (new_pkt) begin
      pkt_len  = 0;
      seg_cnt  = 0;
      fill_pos = ip_on ? 32'(rdbs_pkg::IP_START) : 32'd0;
      new_pkt  = 1'b0;
    end
    pkt_len += 32'(it.length);
    if (pkt_len > rdbs_pkg::LEN_MAX) pkt_len = 32'(rdbs_pkg::LEN_MAX);
    pkt_end = !it.chain || it.ring_end;
    if (pkt_end) new_pkt = 1'b1;
    ofs = 64'(it.offset);
    r = '0;
    r.src_region   = it.region;
    r.packet_bytes = 20'(pkt_len);
    r.packet_done  = pkt_end;
    if (ofs + 64'(it.length) > 64'(rgn_size[it.region])) begin
      r.segment_index = 8'(seg_cnt);
      r.overrun       = 1'b1;
      r.last          = 1'b1;
      pending_copies.push_back(r);
      return;
    end
    left    = 64'(it.length);
    src_pos = 0;
    n       = 0;
    do begin
      if (fill_pos >= bufsz) begin
        fill_pos = 0;
        if (seg_cnt < rdbs_pkg::SEG_MAX) seg_cnt++;
      end
      room = 64'(bufsz - fill_pos);
      take = (room < left) ? room : left;
      left -= take;
      r.src_offset    = 33'(ofs + src_pos);
      r.copy_bytes    = 15'(take);
      r.dst_offset    = 14'(fill_pos);
      r.segment_index = 8'(seg_cnt);
      r.packet_done   = pkt_end && (left == 0);
      r.last          = (left == 0);
      pending_copies.push_back(r);
      n++;
      src_pos  += take;
      fill_pos += 32'(take);
    end while (left != 0 && n < MAX_COPIES);
  endfunction

  function automatic void check_field(input string name, input logic [32:0] want,
                                      input logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : copy_checker
    rdbs_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_copies.size() == 0) begin
        $display("%0t: result expected none got region %0h src %0h bytes %0h", $time,
                 out_src_region, out_src_offset, out_copy_bytes);
        mismatches++;
      end else begin
        want = pending_copies.pop_front();
        check_field("src_region", want.src_region, out_src_region);
        check_field("src_offset", want.src_offset, out_src_offset);
        check_field("copy_bytes", want.copy_bytes, out_copy_bytes);
        check_field("dst_offset", want.dst_offset, out_dst_offset);
        check_field("segment_index", want.segment_index, out_segment_index);
        check_field("overrun", want.overrun, out_overrun);
        check_field("packet_done", want.packet_done, out_packet_done);
        check_field("packet_bytes", want.packet_bytes, out_packet_bytes);
        check_field("last", want.last, out_last);
      end
    end
  end

  // receiver stalls in runs; a hold request forces one long stretch
  initial begin : rx_pacing
    int run;
    bit lvl;
    run = 0;
    lvl = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
        run = 0;
      end else begin
        if (run == 0) begin
          lvl = ($urandom_range(99) < stall_pct);
          run = $urandom_range(1, 12);
        end
        out_stall <= lvl;
        run--;
      end
    end
  end

  task automatic send_item(input ring_item_t it);
    in_valid        <= 1'b1;
    in_cmd          <= it.cmd;
    in_region_index <= it.region;
    in_desc_offset  <= it.offset;
    in_desc_length  <= it.length;
    in_chain_next   <= it.chain;
    in_ring_end     <= it.ring_end;
    in_region_bytes <= it.rbytes;
    do @(posedge clk); while (in_stall);
    split_descriptor(it);
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic ring_item_t make_desc(input logic [3:0] r, input logic [31:0] ofs,
                                           input logic [15:0] len, input bit ch, input bit re);
    ring_item_t it;
    it.cmd      = rdbs_pkg::CMD_DESC;
    it.region   = r;
    it.offset   = ofs;
    it.length   = len;
    it.chain    = ch;
    it.ring_end = re;
    it.rbytes   = $urandom();
    return it;
  endfunction

  function automatic ring_item_t make_size_write(input logic [3:0] r, input logic [31:0] size);
    ring_item_t it;
    it.cmd      = rdbs_pkg::CMD_TABLE;
    it.region   = r;
    it.offset   = $urandom();
    it.length   = 16'($urandom_range(65535));
    it.chain    = 1'($urandom_range(1));
    it.ring_end = 1'($urandom_range(1));
    it.rbytes   = size;
    return it;
  endfunction

  // an offset that keeps the descriptor inside its region where possible
  function automatic logic [31:0] fit_offset(input logic [3:0] r, input logic [15:0] len);
    if (rgn_size[r] >= 32'(len)) return $urandom_range(rgn_size[r] - 32'(len));
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_region_size();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return $urandom_range(70000);
      2: return $urandom();
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_desc(input logic [3:0] r, input logic [31:0] ofs,
                           input logic [15:0] len, input bit ch, input bit re);
    send_item(make_desc(r, ofs, len, ch, re));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_copies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rdbs_pkg::CFG_IDX_W-1:0] idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic set_config(input int unsigned raw_size, input bit ip);
    logic [14:0] w;
    w = 15'($urandom());
    w[0] = ip;
    wait_idle();
    write_reg(rdbs_pkg::REG_BUFFER_BYTES, 15'(raw_size));
    write_reg(rdbs_pkg::REG_IP_MODE, w);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    gap_max   = 3;
    stall_pct = 30;
    send_item(make_size_write(4'd0, 32'hFFFF_FFFF));
    send_item(make_size_write(4'd15, 32'd0));
    send_item(make_size_write(4'd7, 32'd5000));
    send_desc(4'd0, 32'd0, 16'd0, 1'b0, 1'b0);
    send_desc(4'd0, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0);
    send_desc(4'd0, 32'hFFFF_FFFF, 16'd1, 1'b0, 1'b0);
    send_desc(4'd15, 32'd0, 16'd0, 1'b0, 1'b0);
    send_desc(4'd15, 32'd0, 16'd1, 1'b0, 1'b0);
    send_desc(4'd7, 32'd3000, 16'd2000, 1'b0, 1'b0);
    send_desc(4'd7, 32'd3001, 16'd2000, 1'b0, 1'b0);
    send_desc(4'd0, 32'd100, 16'hFFFF, 1'b0, 1'b0);
    // fill one buffer exactly, then a zero length item must open the next
    send_desc(4'd0, 32'd0, 16'd2048, 1'b1, 1'b0);
    send_desc(4'd0, 32'd0, 16'd0, 1'b1, 1'b0);
    send_desc(4'd7, 32'd4000, 16'd2000, 1'b1, 1'b0);
    send_desc(4'd0, 32'd5, 16'd3000, 1'b1, 1'b1);
    send_desc(4'd0, 32'd0, 16'd1500, 1'b1, 1'b0);
    send_desc(4'd0, 32'd0, 16'd1500, 1'b0, 1'b0);
  endtask

  task automatic test_register_settings();
    int unsigned raw_sizes [7];
    bit          ip_modes [7];
    raw_sizes = '{0, 2047, 32767, 16385, 16384, 2048, 0};
    ip_modes  = '{1, 0, 1, 0, 1, 0, 0};
    raw_sizes[6] = $urandom_range(32767);
    ip_modes[6]  = 1'($urandom_range(1));
    gap_max   = 2;
    stall_pct = 20;
    for (int i = 0; i < 7; i++) begin
      set_config(raw_sizes[i], ip_modes[i]);
      send_desc(4'd0, fit_offset(4'd0, 16'd20000), 16'd20000, 1'b1, 1'b0);
      send_desc(4'd0, fit_offset(4'd0, 16'd100), 16'd100, 1'b0, 1'b0);
      send_desc(4'd0, fit_offset(4'd0, 16'd16384), 16'd16384, 1'b1, 1'b1);
    end
    // unused register indexes must leave the setup alone
    wait_idle();
    write_reg(REG_SPARE2, 15'($urandom()));
    write_reg(REG_SPARE3, 15'($urandom()));
    cfg_valid <= 1'b0;
    send_desc(4'd0, fit_offset(4'd0, 16'd5000), 16'd5000, 1'b0, 1'b0);
    send_desc(4'd0, fit_offset(4'd0, 16'd40000), 16'd40000, 1'b0, 1'b0);
  endtask

  task automatic test_buffer_resize();
    gap_max   = 0;
    stall_pct = 40;
    set_config(16384, 1'b1);
    send_desc(4'd0, 32'd0, 16'd10000, 1'b1, 1'b0);
    // shrink below the fill level mid packet
    set_config(2048, 1'b1);
    send_desc(4'd0, 32'd0, 16'd3000, 1'b1, 1'b0);
    set_config(4096, 1'b0);
    send_desc(4'd0, 32'd0, 16'd5000, 1'b0, 1'b0);
  endtask

  task automatic test_saturation();
    gap_max   = 0;
    stall_pct = 0;
    set_config(2048, 1'b0);
    repeat (9) send_desc(4'd0, fit_offset(4'd0, 16'hFFFF), 16'hFFFF, 1'b1, 1'b0);
    // bad items still add length, pushing the packet past its maximum
    repeat (8) send_desc(4'd15, $urandom(), 16'hFFFF, 1'b1, 1'b0);
    send_desc(4'd0, 32'd0, 16'd100, 1'b0, 1'b0);
    send_desc(4'd0, 32'd0, 16'd10, 1'b0, 1'b0);
  endtask

  task automatic test_output_backpressure();
    logic [15:0] len;
    gap_max   = 0;
    stall_pct = 20;
    set_config(2048, 1'b1);
    hold_req = 1'b1;
    repeat (20) begin
      len = 16'($urandom_range(5000));
      send_desc(4'd0, fit_offset(4'd0, len), len, 1'($urandom_range(1)), 1'b0);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    ring_item_t  it;
    int          sent, ndesc;
    logic [3:0]  r;
    logic [15:0] len;
    int unsigned raw;
    for (int i = 0; i < rdbs_pkg::REGION_COUNT; i++)
      send_item(make_size_write(4'(i), pick_region_size()));
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin gap_max = 0;  stall_pct = 0;  end
        1: begin gap_max = 4;  stall_pct = 30; end
        2: begin gap_max = 10; stall_pct = 60; end
        3: begin gap_max = 2;  stall_pct = 10; end
        default: begin gap_max = 6; stall_pct = 80; end
      endcase
      case ($urandom_range(4))
        0: raw = 0;
        1: raw = 2048;
        2: raw = 16384;
        3: raw = 32767;
        default: raw = $urandom_range(32767);
      endcase
      set_config(raw, 1'($urandom_range(1)));
      repeat (3) send_item(make_size_write(4'($urandom_range(15)), pick_region_size()));
      sent = 3;
      while (sent < 30) begin
        if ($urandom_range(9) == 0) begin
          // noise: any field, any command
          it.cmd      = 1'($urandom_range(1));
          it.region   = 4'($urandom_range(15));
          it.offset   = $urandom();
          it.length   = 16'($urandom_range(65535));
          it.chain    = 1'($urandom_range(1));
          it.ring_end = 1'($urandom_range(1));
          it.rbytes   = $urandom();
          send_item(it);
          sent++;
        end else begin
          ndesc = $urandom_range(1, 4);
          for (int i = 0; i < ndesc; i++) begin
            r = 4'($urandom_range(15));
            case ($urandom_range(19))
              0: len = 16'd0;
              1, 2: len = 16'($urandom_range(65535, 8000));
              default: len = 16'($urandom_range(3000));
            endcase
            it = make_desc(r, ($urandom_range(9) == 0) ? $urandom() : fit_offset(r, len),
                           len, i < ndesc - 1, $urandom_range(19) == 0);
            send_item(it);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_register_settings();
    test_buffer_resize();
    test_saturation();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_copies.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule
